>>> sv/ishp_pkg.sv
package ishp_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_W     = 1;
  localparam int TDATA_IN_W      = 24;
  localparam int TUSER_IN_W      = 2;
  localparam int TDATA_OUT_W     = 8;

  // commands
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_REGISTER = 2'd1;
  localparam logic [1:0] CMD_STRATEGY = 2'd2;

  // machine states
  localparam logic [2:0] ST_WAIT_REG  = 3'd0;
  localparam logic [2:0] ST_INIT      = 3'd1;
  localparam logic [2:0] ST_WAIT_TRIG = 3'd2;
  localparam logic [2:0] ST_SETUP     = 3'd3;
  localparam logic [2:0] ST_HOLD      = 3'd4;
  localparam logic [2:0] ST_DEINIT    = 3'd5;

  // registered line polarity
  localparam logic [1:0] POL_NONE    = 2'd0;
  localparam logic [1:0] POL_RISING  = 2'd1;
  localparam logic [1:0] POL_FALLING = 2'd2;

  // strategies
  localparam logic [1:0] STRAT_CANCEL = 2'd0;
  localparam logic [1:0] STRAT_INIT   = 2'd1;
  localparam logic [1:0] STRAT_START  = 2'd2;
  localparam logic [1:0] STRAT_DEINIT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DEASSERTED = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_ASSERTED   = 1'd1;

  localparam logic [CFG_WIDTH-1:0] MIN_TIME_RESET = 16'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  strategy;
    logic        polarity;
    logic [15:0] elapsed_time;
  } item_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       accepted;
    logic       pin_level;
    logic       pin_driven;
  } result_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] min_asserted_time;
    logic [CFG_WIDTH-1:0] min_deasserted_time;
  } cfg_regs_t;

endpackage

>>> sv/intb_setup_hold_pulser.sv
// Interrupt line pulser for a host INTB pin.
// Input stream: s_axis_tuser carries the command (tick, register polarity,
// set strategy); s_axis_tdata carries elapsed time, polarity and strategy.
// Every transaction yields exactly one result transaction on m_axis with the
// line drive flag, the line level, the accept flag and the new state.
// cfg_* writes the two minimum times (index 0 deasserted, 1 asserted); it is
// always ready; the user must write it only while no item is in flight, as
// the block does not enforce this. Throughput: one item per cycle while
// m_axis_tready is high. An item passes through the input register and then
// through the state update into the result register; the state machine and
// timers update once per item.
// Reset (rst, synchronous) empties both registers, returns the machine to the
// wait register state with no polarity, cancel strategy, zero timers, line
// low, and both minimums to 2.
// When m_axis_tready is low the result is held; one further item is taken
// into the input register and then s_axis_tready drops until the result
// register drains.
module intb_setup_hold_pulser
  import ishp_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // elapsed_time[15:0], polarity, strategy[1:0], pad
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,  // command[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // pin_driven, pin_level, accepted, state_code[2:0], pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data
);

  item_t     item_q;
  logic      in_valid;
  result_t   core_res;
  result_t   res_q;
  logic      out_valid;
  logic      advance;
  cfg_regs_t cfg_regs;

  assign cfg_ready = 1'b1;

  ishp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg_regs)
  );

  assign advance       = in_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.command      <= s_axis_tuser;
      item_q.elapsed_time <= s_axis_tdata[15:0];
      item_q.polarity     <= s_axis_tdata[16];
      item_q.strategy     <= s_axis_tdata[18:17];
    end
  end

  ishp_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg_regs),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, res_q};

`ifndef NO_ASSERTIONS
  // hold a pending item until it can move on
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("pending input item dropped");

  // drive the line on ticks only
  a_cmd_no_drive: assert property (@(posedge clk) disable iff (rst)
    advance && item_q.command != CMD_TICK |-> !core_res.pin_driven)
    else $error("command transaction drove the line");

  // accept every tick
  a_tick_acc: assert property (@(posedge clk) disable iff (rst)
    advance && item_q.command == CMD_TICK |-> core_res.accepted)
    else $error("tick not accepted");

  // a refused command leaves the state code alone
  a_refused_state: assert property (@(posedge clk) disable iff (rst)
    advance && item_q.command != CMD_TICK && !core_res.accepted && out_valid
    && m_axis_tready |-> core_res.state_code == res_q.state_code)
    else $error("refused command changed the state");
`endif

endmodule

>>> sv/ishp_cfg.sv
module ishp_cfg
  import ishp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_WIDTH-1:0]   wr_data,
  output cfg_regs_t              regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_deasserted_time <= MIN_TIME_RESET;
      regs.min_asserted_time   <= MIN_TIME_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_DEASSERTED: regs.min_deasserted_time <= wr_data;
        REG_MIN_ASSERTED:   regs.min_asserted_time   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/ishp_core.sv
module ishp_core
  import ishp_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  item_t     item,
  input  cfg_regs_t cfg,
  output result_t   result
);

  // storage wide enough for both the saturation limit and the 16-bit minimums
  localparam int TW  = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam int TWP = TW + 1;
  localparam logic [TW:0] TMAX = TWP'((64'd1 << TIMER_WIDTH) - 64'd1);

  logic [2:0]    state, state_next;
  logic [1:0]    pol, pol_next;
  logic [1:0]    strat, strat_next;
  logic [TW-1:0] asrt, asrt_next;
  logic [TW-1:0] deas, deas_next;
  logic          level, level_next;
  logic          drove, acc;

  logic [TW-1:0] dte, lim_d, lim_a;
  logic [TW-1:0] d_bnd, d_bnd_sat, d_sat, a_bnd, a_sat;
  logic          lvl_idle, lvl_active;

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > TMAX) ? TMAX[TW-1:0] : s[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] bounded_add(logic [TW-1:0] t, logic [TW-1:0] d,
                                                logic [TW-1:0] lim);
    return (t < lim) ? sat_add(t, d) : lim;
  endfunction

  assign dte   = TW'(item.elapsed_time);
  assign lim_d = TW'(cfg.min_deasserted_time);
  assign lim_a = TW'(cfg.min_asserted_time);

  assign d_bnd     = bounded_add(deas, dte, lim_d);
  assign d_bnd_sat = sat_add(d_bnd, dte);
  assign d_sat     = sat_add(deas, dte);
  assign a_bnd     = bounded_add(asrt, dte, lim_a);
  assign a_sat     = sat_add(asrt, dte);

  assign lvl_active = (pol == POL_RISING);
  assign lvl_idle   = ~lvl_active;

  always_comb begin
    state_next = state;
    pol_next   = pol;
    strat_next = strat;
    asrt_next  = asrt;
    deas_next  = deas;
    level_next = level;
    drove      = 1'b0;
    acc        = 1'b0;
    case (item.command)
      CMD_TICK: begin
        acc = 1'b1;
        case (state)
          ST_WAIT_REG: begin
            if (strat == STRAT_INIT && pol != POL_NONE) state_next = ST_INIT;
          end
          ST_INIT: begin
            level_next = lvl_idle;
            drove      = 1'b1;
            deas_next  = d_bnd;
            state_next = ST_WAIT_TRIG;
          end
          ST_WAIT_TRIG: begin
            level_next = lvl_idle;
            drove      = 1'b1;
            deas_next  = d_bnd;
            if (strat == STRAT_START) begin
              // the bounded update counts first, then the start decision looks again
              if (d_bnd < lim_d) begin
                deas_next  = d_bnd_sat;
                state_next = ST_SETUP;
              end else begin
                level_next = lvl_active;
                deas_next  = '0;
                asrt_next  = a_bnd;
                state_next = ST_HOLD;
              end
            end else if (strat == STRAT_DEINIT) begin
              state_next = ST_DEINIT;
            end
          end
          ST_SETUP: begin
            if (strat == STRAT_CANCEL) begin
              state_next = ST_WAIT_TRIG;
              deas_next  = '0;
            end else if (deas < lim_d) begin
              deas_next = d_sat;
            end else begin
              level_next = lvl_active;
              drove      = 1'b1;
              deas_next  = '0;
              asrt_next  = a_bnd;
              state_next = ST_HOLD;
            end
          end
          ST_HOLD: begin
            if (asrt < lim_a) begin
              asrt_next = a_sat;
            end else begin
              level_next = lvl_idle;
              drove      = 1'b1;
              strat_next = STRAT_CANCEL;
              state_next = ST_WAIT_TRIG;
              asrt_next  = '0;
              deas_next  = d_bnd;
            end
          end
          ST_DEINIT: begin
            level_next = 1'b0;
            drove      = 1'b1;
            pol_next   = POL_NONE;
            state_next = ST_WAIT_REG;
            asrt_next  = '0;
            deas_next  = '0;
          end
          default: state_next = ST_WAIT_REG;
        endcase
      end
      CMD_REGISTER: begin
        if (state == ST_WAIT_REG) begin
          pol_next = item.polarity ? POL_FALLING : POL_RISING;
          acc      = 1'b1;
        end
      end
      CMD_STRATEGY: begin
        if (pol != POL_NONE) begin
          strat_next = item.strategy;
          acc        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT_REG;
      pol   <= POL_NONE;
      strat <= STRAT_CANCEL;
      asrt  <= '0;
      deas  <= '0;
      level <= 1'b0;
    end else if (step) begin
      state <= state_next;
      pol   <= pol_next;
      strat <= strat_next;
      asrt  <= asrt_next;
      deas  <= deas_next;
      level <= level_next;
    end
  end

  assign result.pin_driven = drove;
  assign result.pin_level  = level_next;
  assign result.accepted   = acc;
  assign result.state_code = state_next;

endmodule
